/* sv/rrqs_pkg.sv */
// rrqs_pkg: shared types and constants of the round-robin quantum scheduler
`timescale 1ns / 1ps
`default_nettype none
package rrqs_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam logic [15:0] TIME_SLICE_RESET = 16'd4;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RING,
        ST_TABLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        all_finished;
        logic [31:0] clock_now;
        logic [15:0] left_over;
        logic [15:0] ran_for;
        logic [15:0] ran_id;
        logic        done_res;
    } result_t;

    function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
        return {{(OUT_DATA_W - $bits(result_t)){1'b0}}, r};
    endfunction

endpackage
`default_nettype wire

/* sv/rrqs_ram.sv */
// rrqs_ram: single write port, single read port memory with registered read
`timescale 1ns / 1ps
`default_nettype none
module rrqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* sv/round_robin_quantum_scheduler.sv */
// round_robin_quantum_scheduler: task table, ready ring and scheduling control
// An add word stores a task in the next free slot and queues it; it is refused once
// CAPACITY tasks have been admitted since reset. A run word passes ST_RING and ST_TABLE:
// the ring memory is read at the head, the task memory is read at that slot, then the task
// is run for min(time_slice, remaining), written back and requeued unless finished. A run
// on an empty ring is answered from ST_IDLE. One word is in work at a time; a finished
// result sits in the output register while the next word is accepted, and work stalls only
// when a second result is ready before the first is taken. The user must write time_slice
// by cfg_wr_en, cfg_wr_data only while idle (not enforced). No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_quantum_scheduler
    import rrqs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [15:0]           cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // task_id, work_needed
    input  wire logic                  s_tuser,   // kind
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata    // done_res, ran_id, ran_for, left_over,
                                                  // clock_now, all_finished
);

    localparam int SW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SUMW = CW + 1;

    state_t        state_reg, state_next;
    logic [15:0]   time_slice_reg;
    logic [SW-1:0] head_reg, head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] admitted_reg, admitted_next;
    logic [31:0]   elapsed_reg, elapsed_next;
    result_t       res_reg, res_cur;
    logic          m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic          tbl_we;
    logic [SW-1:0] tbl_waddr;
    logic [31:0]   tbl_wdata;
    logic [31:0]   tbl_rdata;
    logic          ring_we;
    logic [SW-1:0] ring_wdata;
    logic [SW-1:0] ring_rdata;
    logic [SW-1:0] tail;
    logic [SUMW-1:0] tail_sum;

    logic          accept;
    logic          out_free;
    logic          fin;
    logic [15:0]   rem_cur;
    logic [15:0]   run_amt;
    logic [15:0]   rem_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // tail slot of the ring
    assign tail_sum = SUMW'(head_reg) + SUMW'(fill_reg);
    assign tail = (tail_sum >= SUMW'(CAPACITY)) ? SW'(tail_sum - SUMW'(CAPACITY))
                                                : SW'(tail_sum);

    assign rem_cur = tbl_rdata[15:0];
    assign run_amt = (rem_cur > time_slice_reg) ? time_slice_reg : rem_cur;
    assign rem_new = rem_cur - run_amt;

    rrqs_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_task_mem (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (ring_rdata),
        .rdata (tbl_rdata)
    );

    rrqs_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_ring_mem (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (tail),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_RUN && fill_reg != '0) begin
                        state_next = ST_RING;
                    end else begin
                        state_next = out_free ? ST_IDLE : ST_EMIT;
                    end
                end
            end
            ST_RING: begin
                state_next = ST_TABLE;
            end
            ST_TABLE: begin
                state_next = out_free ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                state_next = out_free ? ST_IDLE : ST_EMIT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        tbl_we        = 1'b0;
        tbl_waddr     = admitted_reg[SW-1:0];
        tbl_wdata     = {s_tdata[15:0], s_tdata[31:16]};
        ring_we       = 1'b0;
        ring_wdata    = admitted_reg[SW-1:0];
        head_next     = head_reg;
        fill_next     = fill_reg;
        admitted_next = admitted_reg;
        elapsed_next  = elapsed_reg;
        fin           = 1'b0;
        res_cur       = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == KIND_ADD) begin
                        fin = 1'b1;
                        res_cur = '0;
                        if (admitted_reg < CW'(CAPACITY)) begin
                            tbl_we        = 1'b1;
                            ring_we       = 1'b1;
                            fill_next     = fill_reg + 1'b1;
                            admitted_next = admitted_reg + 1'b1;
                            res_cur.done_res = 1'b1;
                        end
                        res_cur.clock_now    = elapsed_reg;
                        res_cur.all_finished = (fill_next == '0);
                    end else if (fill_reg == '0) begin
                        fin = 1'b1;
                        res_cur = '0;
                        res_cur.clock_now    = elapsed_reg;
                        res_cur.all_finished = 1'b1;
                    end
                end
            end
            ST_TABLE: begin
                fin          = 1'b1;
                tbl_we       = 1'b1;
                tbl_waddr    = ring_rdata;
                tbl_wdata    = {tbl_rdata[31:16], rem_new};
                head_next    = (head_reg == SW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
                elapsed_next = elapsed_reg + 32'(run_amt);
                ring_wdata   = ring_rdata;
                if (rem_new != '0) begin
                    ring_we = 1'b1;
                end else begin
                    fill_next = fill_reg - 1'b1;
                end
                res_cur.done_res     = 1'b1;
                res_cur.ran_id       = tbl_rdata[31:16];
                res_cur.ran_for      = run_amt;
                res_cur.left_over    = rem_new;
                res_cur.clock_now    = elapsed_next;
                res_cur.all_finished = (fill_next == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            time_slice_reg <= TIME_SLICE_RESET;
            head_reg       <= '0;
            fill_reg       <= '0;
            admitted_reg   <= '0;
            elapsed_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            admitted_reg <= admitted_next;
            elapsed_reg  <= elapsed_next;
            if (cfg_wr_en) begin
                time_slice_reg <= cfg_wr_data;
            end
            if ((fin || state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) begin
            res_reg <= res_cur;
        end
        if (fin && out_free) begin
            m_tdata_reg <= pack_result(res_cur);
        end else if (state_reg == ST_EMIT && out_free) begin
            m_tdata_reg <= pack_result(res_reg);
        end
    end

`ifndef SYNTHESIS
    a_fill_le_admitted: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= admitted_reg)
        else $error("ring holds more entries than admitted tasks");

    a_admitted_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        admitted_reg <= CW'(CAPACITY))
        else $error("admission count beyond capacity");

    a_ring_then_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RING |=> state_reg == ST_TABLE)
        else $error("ring read not followed by table read");

    a_run_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TABLE |-> fill_reg != '0)
        else $error("task run with an empty ring");
`endif

endmodule
`default_nettype wire
